### hdl/lz77_history_window_copier_macros.svh
// Assertion macros for the LZ77 history window copier.
// Used by the RTL files that carry concurrent assertions; depends on nothing.
`ifndef LZ77_HISTORY_WINDOW_COPIER_MACROS_SVH
`define LZ77_HISTORY_WINDOW_COPIER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define LZHW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzhw assertion failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define LZHW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzhw assertion failed");
`else
`define LZHW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LZHW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/lzhw_pkg.sv
// Shared types, field widths, request codes and the CRC-32 byte update
// for the LZ77 history window copier. Depends on nothing.
`default_nettype none

package lzhw_pkg;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int LIT_W      = 8;
    localparam int OFF_W      = 15;
    localparam int LEN_W      = 9;
    localparam int CRC_W      = 32;
    localparam int TOT_W      = 32;
    localparam int FILL_OUT_W = 16;

    // Request codes on the input port
    localparam logic [REQ_W-1:0] REQ_LITERAL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COPY    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEGMENT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESET   = 2'd3;

    // gzip CRC-32, reflected
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_LITERAL,
        OP_COPY,
        OP_EMPTY_COPY,
        OP_SEGMENT,
        OP_RESET
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [LIT_W-1:0] lit;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Queue status toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Fold one byte into the CRC register, LSB first
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [LIT_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-LIT_W){1'b0}}, b};
        for (int k = 0; k < LIT_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/lzhw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module lzhw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire [WIDTH-1:0]          i_wr_data,
    input  wire                      i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/lzhw_cmd_queue.sv
// Short command queue between the front and back ends of the copier.
// Depends on lzhw_pkg.
`default_nettype none

module lzhw_cmd_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  lzhw_pkg::t_cmd  i_cmd,
    input  wire             i_pop,
    output logic            o_full,
    output lzhw_pkg::t_q_head o_head
);
    import lzhw_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lzhw_front.sv
// Front end: accepts transactions on the start/busy port and classifies
// each request into a queue command. Depends on lzhw_pkg.
`default_nettype none

module lzhw_front (
    input  wire                          i_start,
    input  wire [lzhw_pkg::REQ_W-1:0]    i_req_type,
    input  wire [lzhw_pkg::LIT_W-1:0]    i_literal_byte,
    input  wire [lzhw_pkg::OFF_W-1:0]    i_back_offset,
    input  wire [lzhw_pkg::LEN_W-1:0]    i_copy_length,
    input  wire                          i_q_full,
    output logic                         o_busy,
    output logic                         o_push,
    output lzhw_pkg::t_cmd               o_cmd
);
    import lzhw_pkg::*;

    // Hold off new transactions while the queue is full
    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;

    // Classify the request; a zero-length copy only reports status
    always_comb begin
        o_cmd.lit = i_literal_byte;
        o_cmd.off = i_back_offset;
        o_cmd.len = i_copy_length;
        case (i_req_type)
            REQ_LITERAL: o_cmd.op = OP_LITERAL;
            REQ_COPY:    o_cmd.op = (i_copy_length == '0) ? OP_EMPTY_COPY : OP_COPY;
            REQ_SEGMENT: o_cmd.op = OP_SEGMENT;
            REQ_RESET:   o_cmd.op = OP_RESET;
            default:     o_cmd.op = OP_RESET;
        endcase
    end

endmodule

`default_nettype wire

### hdl/lzhw_back.sv
// Back end: executes queued commands against the history RAM, keeps the
// write pointer, fill count, CRC-32 and byte total. Depends on lzhw_pkg,
// lzhw_ram and the assertion macro header.
`default_nettype none
`include "lz77_history_window_copier_macros.svh"

module lzhw_back #(
    parameter int WINDOW_DEPTH = 32768
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lzhw_pkg::t_q_head                  i_head,
    output logic                               o_pop,
    output logic                               o_done,
    output logic [lzhw_pkg::CRC_W-1:0]         o_crc_value,
    output logic [lzhw_pkg::TOT_W-1:0]         o_total_bytes,
    output logic [lzhw_pkg::FILL_OUT_W-1:0]    o_window_fill,
    output logic                               o_range_error
);
    import lzhw_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int FW   = $clog2(WINDOW_DEPTH + 1);
    localparam int CMPW = (FW > OFF_W) ? FW : OFF_W;
    localparam int SW   = ((AW > OFF_W) ? AW : OFF_W) + 2;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    t_state            r_state,      n_state;
    logic [AW-1:0]     r_wr_ptr,     n_wr_ptr;
    logic [FW-1:0]     r_fill,       n_fill;
    logic [CRC_W-1:0]  r_crc,        n_crc;
    logic [TOT_W-1:0]  r_total,      n_total;
    logic [AW-1:0]     r_src,        n_src;
    logic [LEN_W-1:0]  r_issue_left, n_issue_left;
    logic              r_dv;
    logic              r_fwd;
    logic [LIT_W-1:0]  r_fwd_data;
    logic              r_done,       n_done;
    logic              r_err,        n_err;

    logic              pop;
    logic              range_err;
    logic              rd_en;
    logic [LIT_W-1:0]  ram_q;
    logic [LIT_W-1:0]  copy_byte;
    logic              append_en;
    logic [LIT_W-1:0]  append_byte;
    logic [SW-1:0]     src_sum;
    logic [SW-1:0]     src_red;
    logic [FW+FILL_OUT_W-1:0] fill_ext;

    // History RAM
    lzhw_ram #(
        .WIDTH (LIT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (append_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (append_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_src),
        .o_rd_data (ram_q)
    );

    // Take the next command whenever no copy is running
    assign pop   = (r_state == ST_IDLE) && i_head.valid;
    assign o_pop = pop;

    // Distance check against the current fill
    assign range_err = (CMPW'(i_head.cmd.off) >= CMPW'(r_fill));

    // First source byte: wr_ptr - (off + 1), modulo the window depth
    assign src_sum = SW'(r_wr_ptr) + SW'(WINDOW_DEPTH) - SW'(i_head.cmd.off) - SW'(1);
    assign src_red = (src_sum >= SW'(WINDOW_DEPTH)) ? (src_sum - SW'(WINDOW_DEPTH)) : src_sum;

    // Copy reads one byte a cycle; bypass the byte written in the read cycle
    assign rd_en     = (r_state == ST_COPY) && (r_issue_left != '0);
    assign copy_byte = r_fwd ? r_fwd_data : ram_q;

    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_fill       = r_fill;
        n_crc        = r_crc;
        n_total      = r_total;
        n_src        = r_src;
        n_issue_left = r_issue_left;
        n_done       = 1'b0;
        n_err        = r_err;
        append_en    = 1'b0;
        append_byte  = i_head.cmd.lit;

        case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    case (i_head.cmd.op)
                        OP_LITERAL: begin
                            append_en = 1'b1;
                            n_done    = 1'b1;
                            n_err     = 1'b0;
                        end
                        OP_COPY: begin
                            if (range_err) begin
                                n_done = 1'b1;
                                n_err  = 1'b1;
                            end else begin
                                n_src        = src_red[AW-1:0];
                                n_issue_left = i_head.cmd.len;
                                n_state      = ST_COPY;
                            end
                        end
                        OP_EMPTY_COPY: begin
                            n_done = 1'b1;
                            n_err  = 1'b0;
                        end
                        OP_SEGMENT: begin
                            n_wr_ptr = '0;
                            n_fill   = '0;
                            n_done   = 1'b1;
                            n_err    = 1'b0;
                        end
                        OP_RESET: begin
                            n_wr_ptr = '0;
                            n_fill   = '0;
                            n_crc    = CRC_INIT;
                            n_total  = '0;
                            n_done   = 1'b1;
                            n_err    = 1'b0;
                        end
                        default: begin
                            n_done = 1'b1;
                            n_err  = 1'b0;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // Issue the next read
                if (rd_en) begin
                    n_src        = (r_src == AW'(WINDOW_DEPTH - 1)) ? '0 : r_src + AW'(1);
                    n_issue_left = r_issue_left - LEN_W'(1);
                end
                // Append the byte read last cycle
                if (r_dv) begin
                    append_en   = 1'b1;
                    append_byte = copy_byte;
                end
                // Last byte written: report
                if (r_dv && (r_issue_left == '0)) begin
                    n_done  = 1'b1;
                    n_err   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Append one byte: advance pointer, grow fill until full, update CRC and byte total
        if (append_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            n_fill   = (r_fill == FW'(WINDOW_DEPTH)) ? r_fill : r_fill + FW'(1);
            n_crc    = crc32_byte(r_crc, append_byte);
            n_total  = r_total + TOT_W'(1);
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wr_ptr     <= '0;
            r_fill       <= '0;
            r_crc        <= CRC_INIT;
            r_total      <= '0;
            r_issue_left <= '0;
            r_dv         <= 1'b0;
            r_fwd        <= 1'b0;
            r_done       <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wr_ptr     <= n_wr_ptr;
            r_fill       <= n_fill;
            r_crc        <= n_crc;
            r_total      <= n_total;
            r_issue_left <= n_issue_left;
            r_dv         <= rd_en;
            r_fwd        <= rd_en && append_en && (r_src == r_wr_ptr);
            r_done       <= n_done;
            r_err        <= n_err;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_fwd_data <= append_byte;
    end

    assign fill_ext      = (FW + FILL_OUT_W)'(r_fill);
    assign o_done        = r_done;
    assign o_crc_value   = ~r_crc;
    assign o_total_bytes = r_total;
    assign o_window_fill = fill_ext[FILL_OUT_W-1:0];
    assign o_range_error = r_err;

    `LZHW_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(WINDOW_DEPTH))
    `LZHW_ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, r_state == ST_IDLE, (r_issue_left == '0) && !r_dv)
    `LZHW_ASSERT_NEXT(a_err_keeps, i_clk, i_rst_n, pop && (i_head.cmd.op == OP_COPY) && range_err, r_done && r_err && (r_fill == $past(r_fill)))
    `LZHW_ASSERT_IMPL(a_fwd_in_copy, i_clk, i_rst_n, r_fwd, r_dv && (r_state == ST_COPY))

endmodule

`default_nettype wire

### hdl/lz77_history_window_copier.sv
// Literal, segment, reset and zero-length or out-of-range copy report once the
// back end takes them; a copy of L bytes reports once its last byte is written.
// Throughput: one such short request per cycle while no copy runs; a copy holds the
// back end, one byte a cycle, set by the single write port of the history RAM.
// Reset: synchronous, active low; clears window, CRC and byte total. The history
// RAM is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module lz77_history_window_copier #(
    parameter int WINDOW_DEPTH = 32768
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire [lzhw_pkg::REQ_W-1:0]         i_req_type,
    input  wire [lzhw_pkg::LIT_W-1:0]         i_literal_byte,
    input  wire [lzhw_pkg::OFF_W-1:0]         i_back_offset,
    input  wire [lzhw_pkg::LEN_W-1:0]         i_copy_length,
    output logic                              o_done,
    output logic [lzhw_pkg::CRC_W-1:0]        o_crc_value,
    output logic [lzhw_pkg::TOT_W-1:0]        o_total_bytes,
    output logic [lzhw_pkg::FILL_OUT_W-1:0]   o_window_fill,
    output logic                              o_range_error
);
    import lzhw_pkg::*;

    logic    q_full;
    logic    push;
    t_cmd    cmd;
    logic    pop;
    t_q_head head;

    // Accept and classify
    lzhw_front u_front (
        .i_start        (start),
        .i_req_type     (i_req_type),
        .i_literal_byte (i_literal_byte),
        .i_back_offset  (i_back_offset),
        .i_copy_length  (i_copy_length),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    // Decouple front and back
    lzhw_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Execute against the history window
    lzhw_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_done        (o_done),
        .o_crc_value   (o_crc_value),
        .o_total_bytes (o_total_bytes),
        .o_window_fill (o_window_fill),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for lz77_history_window_copier: directed rows, then random
// streams of literals, copies, segment breaks and resets, scored by model or typed values.
// Depends on hdl/lzhw_pkg.sv and hdl/lz77_history_window_copier.sv.
`timescale 1ns / 100ps

module tb;
    import lzhw_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int HIST_DEPTH   = 32768;
    localparam int N_ROWS       = 17;
    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_TAIL   = 60;
    localparam int MAX_LEN      = 511;
    // Room for a full queue plus the running copy, all of maximum length, several times over
    localparam int DRAIN_CYCLES = 8 * (MAX_LEN + 8);
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_LIMIT   = 10;
    // Timeout in ns; the slowest legal run is well under half of this
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [LIT_W-1:0] lit;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_lz_request;

    typedef struct packed {
        logic [CRC_W-1:0]      crc;
        logic [TOT_W-1:0]      total;
        logic [FILL_OUT_W-1:0] fill;
        logic                  err;
    } t_lz_status;

    typedef struct {
        t_lz_request rq;
        bit          typed;
        t_lz_status  want;
    } t_stim_row;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [REQ_W-1:0]      i_req_type     = '0;
    logic [LIT_W-1:0]      i_literal_byte = '0;
    logic [OFF_W-1:0]      i_back_offset  = '0;
    logic [LEN_W-1:0]      i_copy_length  = '0;
    logic                  busy;
    logic                  o_done;
    logic [CRC_W-1:0]      o_crc_value;
    logic [TOT_W-1:0]      o_total_bytes;
    logic [FILL_OUT_W-1:0] o_window_fill;
    logic                  o_range_error;

    lz77_history_window_copier #(
        .WINDOW_DEPTH(HIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_literal_byte (i_literal_byte),
        .i_back_offset  (i_back_offset),
        .i_copy_length  (i_copy_length),
        .o_done         (o_done),
        .o_crc_value    (o_crc_value),
        .o_total_bytes  (o_total_bytes),
        .o_window_fill  (o_window_fill),
        .o_range_error  (o_range_error)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Model of the history window, CRC and byte count
    logic [LIT_W-1:0] win_bytes [HIST_DEPTH];
    int               win_oldest;
    int               win_fill;
    logic [CRC_W-1:0] run_crc;
    logic [TOT_W-1:0] run_total;

    t_lz_status  status_queue [$];
    t_stim_row   stim_rows [N_ROWS];
    int          fail_count     = 0;
    int          accepted_count = 0;
    int          checked_count  = 0;
    int          bytes_appended = 0;
    int          range_err_seen = 0;
    int          peak_fill      = 0;
    bit          idle_on        = 1'b0;

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [LIT_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        // Bit-serial LFSR, data LSB first
        for (int i = 0; i < LIT_W; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic window_reset();
        win_oldest = 0;
        win_fill   = 0;
        run_crc    = CRC_INIT;
        run_total  = '0;
    endtask

    task automatic append_to_window(input logic [LIT_W-1:0] b);
        win_bytes[(win_oldest + win_fill) % HIST_DEPTH] = b;
        if (win_fill == HIST_DEPTH) begin
            win_oldest = (win_oldest + 1) % HIST_DEPTH;
        end else begin
            win_fill++;
        end
        run_crc   = crc_fold(run_crc, b);
        run_total = run_total + 1'b1;
        bytes_appended++;
    endtask

    // Advance the model by one request and produce its status
    task automatic window_apply(input t_lz_request rq, output t_lz_status st);
        int pos;
        int n;
        st.err = 1'b0;
        case (rq.req)
            REQ_LITERAL: append_to_window(rq.lit);
            REQ_COPY: begin
                if (rq.len != '0) begin
                    if (int'(rq.off) >= win_fill) begin
                        st.err = 1'b1;
                        range_err_seen++;
                    end else begin
                        // Read position tracks the newest byte, so overlaps repeat
                        for (n = 0; n < int'(rq.len); n++) begin
                            pos = (win_oldest + win_fill - 1 - int'(rq.off)) % HIST_DEPTH;
                            append_to_window(win_bytes[pos]);
                        end
                    end
                end
            end
            REQ_SEGMENT: begin
                win_oldest = 0;
                win_fill   = 0;
            end
            default: window_reset();
        endcase
        if (win_fill > peak_fill) begin
            peak_fill = win_fill;
        end
        st.crc   = ~run_crc;
        st.total = run_total;
        st.fill  = win_fill[FILL_OUT_W-1:0];
    endtask

    // Present one transaction, hold it until accepted, then idle at random
    task automatic send(input t_lz_request rq, input bit typed, input t_lz_status want);
        t_lz_status st;
        start          <= 1'b1;
        i_req_type     <= rq.req;
        i_literal_byte <= rq.lit;
        i_back_offset  <= rq.off;
        i_copy_length  <= rq.len;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        accepted_count++;
        window_apply(rq, st);
        status_queue.push_back(typed ? want : st);
        if (idle_on && accepted_count < N_ROWS + RANDOM_ITEMS - QUIET_TAIL
                && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_checked(input t_lz_request rq);
        send(rq, 1'b0, '0);
    endtask

    function automatic t_lz_request make_req(input logic [REQ_W-1:0] req,
                                             input logic [LIT_W-1:0] lit,
                                             input logic [OFF_W-1:0] off,
                                             input logic [LEN_W-1:0] len);
        t_lz_request rq;
        rq.req = req;
        rq.lit = lit;
        rq.off = off;
        rq.len = len;
        return rq;
    endfunction

    function automatic t_stim_row make_row(input t_lz_request rq, input bit typed,
                                           input logic [CRC_W-1:0] crc,
                                           input logic [TOT_W-1:0] total,
                                           input logic [FILL_OUT_W-1:0] fill,
                                           input logic err);
        t_stim_row r;
        r.rq         = rq;
        r.typed      = typed;
        r.want.crc   = crc;
        r.want.total = total;
        r.want.fill  = fill;
        r.want.err   = err;
        return r;
    endfunction

    // Valid distance, biased half the time toward short overlapping copies
    function automatic logic [OFF_W-1:0] offset_within();
        int hi;
        hi = win_fill - 1;
        if ($urandom_range(0, 1) == 1 && hi > 7) begin
            hi = 7;
        end
        return OFF_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [LEN_W-1:0] copy_len_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3) begin
            return '0;
        end else if (p < 73) begin
            return LEN_W'($urandom_range(1, 16));
        end else if (p < 93) begin
            return LEN_W'($urandom_range(17, 258));
        end
        return LEN_W'($urandom_range(259, MAX_LEN));
    endfunction

    function automatic t_lz_request random_literal();
        return make_req(REQ_LITERAL, LIT_W'($urandom), OFF_W'($urandom), LEN_W'($urandom));
    endfunction

    // Well-formed stream: seed literals, then literals and in-range copies, at times closed by a segment break or reset
    task automatic run_stream();
        t_lz_request rq;
        int          n;
        int          k;
        int          p;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            send_checked(random_literal());
        end
        n = $urandom_range(8, 30);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 25) begin
                rq = random_literal();
            end else begin
                rq = make_req(REQ_COPY, LIT_W'($urandom), offset_within(), copy_len_pick());
            end
            send_checked(rq);
        end
        p = $urandom_range(0, 9);
        if (p < 4) begin
            send_checked(make_req(REQ_SEGMENT, LIT_W'($urandom), OFF_W'($urandom),
                                  LEN_W'($urandom)));
        end else if (p < 6) begin
            send_checked(make_req(REQ_RESET, LIT_W'($urandom), OFF_W'($urandom),
                                  LEN_W'($urandom)));
        end
    endtask

    // Noise and broken sequences: any code, distances at or past the fill or within it
    task automatic run_noise();
        t_lz_request rq;
        int          n;
        int          k;
        int          p;
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) begin
            rq     = make_req(REQ_W'($urandom_range(0, 3)), LIT_W'($urandom),
                              OFF_W'($urandom), '0);
            p      = $urandom_range(0, 99);
            if (p >= 40 && p < 65) begin
                rq.off = OFF_W'(win_fill);
            end else if (p >= 65 && win_fill > 0) begin
                rq.off = offset_within();
            end
            p = $urandom_range(0, 99);
            if (p < 30) begin
                rq.len = LEN_W'($urandom_range(0, 2));
            end else if (p < 85) begin
                rq.len = LEN_W'($urandom_range(1, 32));
            end else begin
                rq.len = LEN_W'($urandom);
            end
            send_checked(rq);
        end
    endtask

    // Fill the whole window with long copies, wrap it, then hit the farthest distance
    task automatic run_fill();
        int k;
        send_checked(random_literal());
        while (win_fill < HIST_DEPTH) begin
            send_checked(make_req(REQ_COPY, LIT_W'($urandom), offset_within(),
                                  LEN_W'(MAX_LEN)));
        end
        for (k = 0; k < 6; k++) begin
            send_checked(make_req(REQ_COPY, LIT_W'($urandom),
                                  (k == 0) ? {OFF_W{1'b1}} : offset_within(),
                                  LEN_W'(MAX_LEN)));
        end
        send_checked(make_req(REQ_COPY, LIT_W'($urandom), {OFF_W{1'b1}},
                              LEN_W'($urandom_range(1, 16))));
        send_checked(make_req(REQ_COPY, LIT_W'($urandom), {OFF_W{1'b1}}, '0));
        send_checked(random_literal());
        send_checked(make_req(REQ_COPY, LIT_W'($urandom), {OFF_W{1'b1}}, 9'd1));
        send_checked(make_req(REQ_SEGMENT, LIT_W'($urandom), OFF_W'($urandom),
                              LEN_W'($urandom)));
    endtask

    // Score every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_lz_status want;
        if (i_rst_n && o_done) begin
            if (status_queue.size() == 0) begin
                flag_failure($sformatf("result with nothing expected: crc=%h total=%0d fill=%0d err=%b",
                                       o_crc_value, o_total_bytes, o_window_fill, o_range_error));
            end else begin
                want = status_queue.pop_front();
                checked_count++;
                if (o_crc_value !== want.crc || o_total_bytes !== want.total
                        || o_window_fill !== want.fill || o_range_error !== want.err) begin
                    flag_failure($sformatf({"result %0d: exp crc=%h total=%0d fill=%0d err=%b,",
                                            " got crc=%h total=%0d fill=%0d err=%b"},
                                           checked_count, want.crc, want.total, want.fill,
                                           want.err, o_crc_value, o_total_bytes,
                                           o_window_fill, o_range_error));
                end
            end
        end
    end

    initial begin : run_timeout
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", status_queue.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int  k;
        int  fill_at;
        bit  fill_done;
        int  drain;
        // Directed rows; typed expectations where the value is obvious
        stim_rows[0]  = make_row(make_req(REQ_SEGMENT, 8'h00, 15'h0000, 9'h000), 1'b1,
                                 32'h0000_0000, 32'd0, 16'd0, 1'b0);
        stim_rows[1]  = make_row(make_req(REQ_COPY, 8'h00, 15'h0000, 9'h001), 1'b1,
                                 32'h0000_0000, 32'd0, 16'd0, 1'b1);
        stim_rows[2]  = make_row(make_req(REQ_COPY, 8'hFF, 15'h7FFF, 9'h000), 1'b1,
                                 32'h0000_0000, 32'd0, 16'd0, 1'b0);
        stim_rows[3]  = make_row(make_req(REQ_LITERAL, 8'h00, 15'h7FFF, 9'h1FF), 1'b1,
                                 32'hD202_EF8D, 32'd1, 16'd1, 1'b0);
        stim_rows[4]  = make_row(make_req(REQ_COPY, 8'h00, 15'h0001, 9'h001), 1'b1,
                                 32'hD202_EF8D, 32'd1, 16'd1, 1'b1);
        stim_rows[5]  = make_row(make_req(REQ_COPY, 8'h00, 15'h0000, 9'h001), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[6]  = make_row(make_req(REQ_LITERAL, 8'hFF, 15'h0000, 9'h000), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[7]  = make_row(make_req(REQ_COPY, 8'h00, 15'h0000, 9'h005), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[8]  = make_row(make_req(REQ_COPY, 8'hFF, 15'h0001, 9'h1FF), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[9]  = make_row(make_req(REQ_COPY, 8'h00, 15'h0002, 9'd258), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[10] = make_row(make_req(REQ_SEGMENT, 8'hFF, 15'h7FFF, 9'h1FF), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[11] = make_row(make_req(REQ_COPY, 8'h00, 15'h0000, 9'h003), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[12] = make_row(make_req(REQ_LITERAL, 8'h5A, 15'h0000, 9'h000), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[13] = make_row(make_req(REQ_COPY, 8'h00, 15'h0000, 9'h000), 1'b0,
                                 '0, '0, '0, 1'b0);
        stim_rows[14] = make_row(make_req(REQ_RESET, 8'hFF, 15'h7FFF, 9'h1FF), 1'b1,
                                 32'h0000_0000, 32'd0, 16'd0, 1'b0);
        stim_rows[15] = make_row(make_req(REQ_LITERAL, 8'h61, 15'h0000, 9'h000), 1'b1,
                                 32'hE8B7_BE43, 32'd1, 16'd1, 1'b0);
        stim_rows[16] = make_row(make_req(REQ_RESET, 8'h00, 15'h0000, 9'h000), 1'b1,
                                 32'h0000_0000, 32'd0, 16'd0, 1'b0);

        window_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed rows
        idle_on = 1'b1;
        for (k = 0; k < N_ROWS; k++) begin
            send(stim_rows[k].rq, stim_rows[k].typed, stim_rows[k].want);
        end

        // Random bursts; the full-window pass lands once at a random point
        fill_at   = N_ROWS + int'($urandom_range(40, 250));
        fill_done = 1'b0;
        while (accepted_count < N_ROWS + RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!fill_done && accepted_count >= fill_at) begin
                run_fill();
                fill_done = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                run_noise();
            end else begin
                run_stream();
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        drain = 0;
        while (status_queue.size() != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_queue.size() != 0) begin
            flag_failure($sformatf("%0d expected results never arrived", status_queue.size()));
        end

        $display("Covered %0d transactions (%0d directed), %0d bytes appended, %0d range errors,",
                 accepted_count, N_ROWS, bytes_appended, range_err_seen);
        $display("peak window fill %0d of %0d; %0d results scored, %0d failures",
                 peak_fill, HIST_DEPTH, checked_count, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### lz77_history_window_copier.f
+incdir+hdl
hdl/lzhw_pkg.sv
hdl/lzhw_ram.sv
hdl/lzhw_cmd_queue.sv
hdl/lzhw_front.sv
hdl/lzhw_back.sv
hdl/lz77_history_window_copier.sv
dv/tb.sv
